FILE: sv/assert_macros.svh
// assertion helpers for the framing encoder
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// checked only while out of reset
`define EFE_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("efe assertion failed");

// checked at every edge, reset included
`define EFE_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("efe assertion failed");

`else

`define EFE_ASSERT(label, clk, rst, prop)
`define EFE_ASSERT_ALWAYS(label, clk, prop)

`endif

`endif

FILE: sv/efe_pkg.sv
`default_nettype none

package efe_pkg;

   localparam logic [7:0] FLAG_BYTE = 8'h7E;
   localparam logic [7:0] ESC_BYTE  = 8'h7D;
   localparam logic [7:0] ESC_FLAG  = 8'h02;
   localparam logic [7:0] ESC_ESC   = 8'h01;

   localparam int QUEUE_DEPTH = 4;

   // one classified message byte, as handed from front to back
   typedef struct packed {
      logic       open;
      logic       last;
      logic [7:0] data;
      logic [7:0] check;
   } item_type;

   typedef enum logic [2:0] {
      PH_OPEN,
      PH_DATA,
      PH_DATA_ESC,
      PH_CHECK,
      PH_CHECK_ESC,
      PH_CLOSE
   } phase_type;

   function automatic logic needs_esc(input logic [7:0] b);
      return b inside {FLAG_BYTE, ESC_BYTE};
   endfunction

   function automatic logic [7:0] esc_first(input logic [7:0] b);
      return needs_esc(b) ? ESC_BYTE : b;
   endfunction

   function automatic logic [7:0] esc_second(input logic [7:0] b);
      return (b == FLAG_BYTE) ? ESC_FLAG : ESC_ESC;
   endfunction

endpackage

`default_nettype wire

FILE: sv/efe_front.sv
`default_nettype none

module efe_front (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire logic [7:0]       req_data_byte,
   input  wire logic             req_final_byte,
   input  wire logic             queue_full,
   output logic                  push,
   output efe_pkg::item_type     push_item
);
   import efe_pkg::*;

   logic [7:0] running_check_ff, running_check_in;
   logic       inside_frame_ff, inside_frame_in;
   logic [7:0] check_now;

   assign req_stall = queue_full;
   assign push      = req_valid & ~queue_full;

   // a closed frame starts its check from zero
   assign check_now = (inside_frame_ff ? running_check_ff : 8'h00) ^ req_data_byte;

   always_comb begin
      push_item.open  = ~inside_frame_ff;
      push_item.last  = req_final_byte;
      push_item.data  = req_data_byte;
      push_item.check = check_now;
   end

   always_comb begin
      running_check_in = running_check_ff;
      inside_frame_in  = inside_frame_ff;
      if (push) begin
         if (req_final_byte) begin
            running_check_in = 8'h00;
            inside_frame_in  = 1'b0;
         end else begin
            running_check_in = check_now;
            inside_frame_in  = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_check_ff <= 8'h00;
         inside_frame_ff  <= 1'b0;
      end else begin
         running_check_ff <= running_check_in;
         inside_frame_ff  <= inside_frame_in;
      end
   end

endmodule

`default_nettype wire

FILE: sv/efe_queue.sv
`default_nettype none

`include "assert_macros.svh"

module efe_queue #(
   parameter int DEPTH = efe_pkg::QUEUE_DEPTH
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire efe_pkg::item_type push_item,
   output logic                   full,
   input  wire logic              pop,
   output logic                   head_valid,
   output efe_pkg::item_type      head_item
);
   import efe_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   item_type           mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_item  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   `EFE_ASSERT(a_no_push_full, clock, reset, full |-> !push)
   `EFE_ASSERT(a_no_pop_empty, clock, reset, !head_valid |-> !pop)
   `EFE_ASSERT(a_count_track, clock, reset,
      !$past(reset) |-> count_ff == $past(count_ff) + CNT_W'($past(push)) - CNT_W'($past(pop)))

endmodule

`default_nettype wire

FILE: sv/efe_back.sv
`default_nettype none

`include "assert_macros.svh"

module efe_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              head_valid,
   input  wire efe_pkg::item_type head_item,
   output logic                   pop,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic [7:0]             rsp_out_byte,
   output logic                   rsp_frame_end
);
   import efe_pkg::*;

   phase_type  phase_ff, phase_in;
   phase_type  cur_phase, nxt_phase;
   logic       done;
   logic       load;
   logic [7:0] byte_now;
   logic       end_now;

   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] out_byte_ff;
   logic       frame_end_ff;

   // an item that continues a frame skips the opening flag
   assign cur_phase = (phase_ff == PH_OPEN && !head_item.open) ? PH_DATA : phase_ff;
   assign load      = head_valid & (~rsp_valid_ff | ~rsp_stall);

   // next state
   always_comb begin
      nxt_phase = PH_OPEN;
      done      = 1'b0;
      case (cur_phase)
         PH_OPEN: begin
            nxt_phase = PH_DATA;
         end
         PH_DATA: begin
            if (needs_esc(head_item.data)) begin
               nxt_phase = PH_DATA_ESC;
            end else if (head_item.last) begin
               nxt_phase = PH_CHECK;
            end else begin
               done = 1'b1;
            end
         end
         PH_DATA_ESC: begin
            if (head_item.last) begin
               nxt_phase = PH_CHECK;
            end else begin
               done = 1'b1;
            end
         end
         PH_CHECK: begin
            nxt_phase = needs_esc(head_item.check) ? PH_CHECK_ESC : PH_CLOSE;
         end
         PH_CHECK_ESC: begin
            nxt_phase = PH_CLOSE;
         end
         PH_CLOSE: begin
            done = 1'b1;
         end
         default: begin
            done = 1'b1;
         end
      endcase
      phase_in = load ? (done ? PH_OPEN : nxt_phase) : phase_ff;
      pop      = load & done;
   end

   // outputs
   always_comb begin
      byte_now = FLAG_BYTE;
      end_now  = 1'b0;
      case (cur_phase)
         PH_OPEN:      byte_now = FLAG_BYTE;
         PH_DATA:      byte_now = esc_first(head_item.data);
         PH_DATA_ESC:  byte_now = esc_second(head_item.data);
         PH_CHECK:     byte_now = esc_first(head_item.check);
         PH_CHECK_ESC: byte_now = esc_second(head_item.check);
         PH_CLOSE: begin
            byte_now = FLAG_BYTE;
            end_now  = 1'b1;
         end
         default:      byte_now = FLAG_BYTE;
      endcase
   end

   assign rsp_valid_in = load | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_OPEN;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         out_byte_ff  <= byte_now;
         frame_end_ff <= end_now;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_byte  = out_byte_ff;
   assign rsp_frame_end = frame_end_ff;

   `EFE_ASSERT(a_end_is_flag, clock, reset,
      rsp_valid && rsp_frame_end |-> rsp_out_byte == FLAG_BYTE)
   `EFE_ASSERT(a_pop_on_load, clock, reset, pop |-> load)
   `EFE_ASSERT(a_mid_item_held, clock, reset, phase_ff != PH_OPEN |-> head_valid)

endmodule

`default_nettype wire

FILE: sv/escape_framing_encoder.sv
// an accepted byte is written into the queue, then registered at the output by the back end
// throughput: one output byte per cycle when queued and not stalled, set by the
//   back-end sequencer (opening flag, 1-2 data bytes, 1-2 check bytes, closing flag)
// a small queue between front and back lets input flow while output is stalled
// reset: synchronous, active high; clears the check, closes any frame, empties
//   the queue and drops any pending output byte
`default_nettype none

module escape_framing_encoder #(
   parameter int QUEUE_DEPTH = efe_pkg::QUEUE_DEPTH
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [7:0] req_data_byte,
   input  wire logic       req_final_byte,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [7:0]      rsp_out_byte,
   output logic            rsp_frame_end
);
   import efe_pkg::*;

   logic     queue_full;
   logic     push;
   item_type push_item;
   logic     pop;
   logic     head_valid;
   item_type head_item;

   efe_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data_byte  (req_data_byte),
      .req_final_byte (req_final_byte),
      .queue_full     (queue_full),
      .push           (push),
      .push_item      (push_item)
   );

   efe_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_item  (push_item),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_item  (head_item)
   );

   efe_back u_back (
      .clock         (clock),
      .reset         (reset),
      .head_valid    (head_valid),
      .head_item     (head_item),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_frame_end (rsp_frame_end)
   );

endmodule

`default_nettype wire
